>>> src/sgrpad_pkg.sv
// ----------------------------------------------------------------------------
// SGR pen decoder package
// Pen record, parse phase codes, SGR code values and small color helpers.
// ----------------------------------------------------------------------------
package sgrpad_pkg;

   localparam int unsigned RGB_WIDTH = 24;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_UL_STYLE   = 3'd1,
      PH_COLOR_MODE = 3'd2,
      PH_PAL_INDEX  = 3'd3,
      PH_RED        = 3'd4,
      PH_GREEN      = 3'd5,
      PH_BLUE       = 3'd6
   } phase_type;

   localparam logic [1:0] TGT_FG = 2'd0;
   localparam logic [1:0] TGT_BG = 2'd1;
   localparam logic [1:0] TGT_UL = 2'd2;

   typedef struct packed {
      logic [4:0]           attrs;
      logic [2:0]           underline;
      logic [RGB_WIDTH-1:0] fg;
      logic [RGB_WIDTH-1:0] bg;
      logic [RGB_WIDTH-1:0] ulc;
      logic [2:0]           defaults;
   } pen_type;

   localparam pen_type PEN_CLEAR = '{attrs: 5'd0, underline: 3'd0, fg: '0, bg: '0,
                                     ulc: '0, defaults: 3'b111};

   // SGR parameter codes
   localparam logic [15:0] CODE_RESET      = 16'd0;
   localparam logic [15:0] CODE_BOLD       = 16'd1;
   localparam logic [15:0] CODE_ITALIC     = 16'd3;
   localparam logic [15:0] CODE_UNDERLINE  = 16'd4;
   localparam logic [15:0] CODE_BLINK      = 16'd5;
   localparam logic [15:0] CODE_REVERSE    = 16'd7;
   localparam logic [15:0] CODE_STRIKE     = 16'd9;
   localparam logic [15:0] CODE_NO_BOLD    = 16'd22;
   localparam logic [15:0] CODE_NO_ITALIC  = 16'd23;
   localparam logic [15:0] CODE_NO_UL      = 16'd24;
   localparam logic [15:0] CODE_NO_BLINK   = 16'd25;
   localparam logic [15:0] CODE_NO_REVERSE = 16'd27;
   localparam logic [15:0] CODE_NO_STRIKE  = 16'd29;
   localparam logic [15:0] CODE_FG_BASE    = 16'd30;
   localparam logic [15:0] CODE_FG_EXT     = 16'd38;
   localparam logic [15:0] CODE_FG_DEF     = 16'd39;
   localparam logic [15:0] CODE_BG_BASE    = 16'd40;
   localparam logic [15:0] CODE_BG_EXT     = 16'd48;
   localparam logic [15:0] CODE_BG_DEF     = 16'd49;
   localparam logic [15:0] CODE_UL_EXT     = 16'd58;
   localparam logic [15:0] CODE_UL_DEF     = 16'd59;
   localparam logic [15:0] CODE_FG_BRIGHT  = 16'd90;
   localparam logic [15:0] CODE_BG_BRIGHT  = 16'd100;
   localparam logic [15:0] COLOR_SPAN      = 16'd7;
   localparam logic [15:0] UL_STYLE_MAX    = 16'd5;
   localparam logic [15:0] MODE_PALETTE    = 16'd5;
   localparam logic [15:0] MODE_RGB        = 16'd2;

   function automatic pen_type color_set(pen_type p, logic [1:0] tgt,
                                         logic [RGB_WIDTH-1:0] rgb);
      pen_type r;
      r = p;
      case (tgt)
         TGT_FG: begin
            r.fg = rgb;
            r.defaults[0] = 1'b0;
         end
         TGT_BG: begin
            r.bg = rgb;
            r.defaults[1] = 1'b0;
         end
         TGT_UL: begin
            r.ulc = rgb;
            r.defaults[2] = 1'b0;
         end
         default: r = p;
      endcase
      return r;
   endfunction

   function automatic pen_type color_default(pen_type p, logic [1:0] tgt);
      pen_type r;
      r = p;
      case (tgt)
         TGT_FG:  r.defaults[0] = 1'b1;
         TGT_BG:  r.defaults[1] = 1'b1;
         TGT_UL:  r.defaults[2] = 1'b1;
         default: r = p;
      endcase
      return r;
   endfunction

   function automatic logic in_span(logic [15:0] s, logic [15:0] base);
      return (s >= base) && (s <= base + COLOR_SPAN);
   endfunction

   // Palette entry used by a 16-color code; meaningless for other codes.
   function automatic logic [3:0] pal_code_index(logic [15:0] s);
      logic [15:0] d;
      if (s >= CODE_BG_BRIGHT) begin
         d = s - CODE_BG_BRIGHT + 16'd8;
      end else if (s >= CODE_FG_BRIGHT) begin
         d = s - CODE_FG_BRIGHT + 16'd8;
      end else if (s >= CODE_BG_BASE) begin
         d = s - CODE_BG_BASE;
      end else begin
         d = s - CODE_FG_BASE;
      end
      return d[3:0];
   endfunction

endpackage

>>> src/sgr_pen_attribute_decoder_top.sv
// ----------------------------------------------------------------------------
// SGR pen attribute decoder
// Decodes SGR parameters one beat at a time into a pen of attributes and
// colors, with a loadable RGB palette for indexed colors.
// ----------------------------------------------------------------------------
// A request beat passes the input register, then the pen register; a
// response stall holds it in the input register.
// Throughput: one beat per cycle unless the response side stalls; the input
// and pen registers each advance once per cycle, and both palette reads fit the input stage.
// Reset clears the pen (all default flags set) and the parse position;
// it does not touch the palette, which needs no clearing pass.
module sgr_pen_attribute_decoder_top #(
   parameter int unsigned PALETTE_DEPTH = 256,
   parameter int unsigned PARAM_WIDTH   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_func,
   input  logic [PARAM_WIDTH-1:0] req_param,
   input  logic                   req_last,
   input  logic [7:0]             req_pal_index,
   input  logic [23:0]            req_pal_rgb,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [4:0]             rsp_attr_bits,
   output logic [2:0]             rsp_underline_style,
   output logic [23:0]            rsp_fg_color,
   output logic [23:0]            rsp_bg_color,
   output logic [23:0]            rsp_ul_color,
   output logic [2:0]             rsp_default_flags
);

   localparam int unsigned AW = $clog2(PALETTE_DEPTH);
   localparam int unsigned SW = (PARAM_WIDTH < 16) ? PARAM_WIDTH : 16;

   // Input stage
   logic          s1_valid_ff;
   logic          s1_func_ff;
   logic [SW-1:0] s1_param_ff;
   logic          s1_last_ff;
   logic          s1_idx_ok_ff;
   logic [23:0]   rd_a_ff;
   logic [23:0]   rd_b_ff;

   logic [23:0]   palette_ff [PALETTE_DEPTH];

   // Pen and parse state
   sgrpad_pkg::pen_type   pen_ff, pen_in;
   sgrpad_pkg::phase_type phase_ff, phase_in;
   logic [1:0]            target_ff, target_in;
   logic [7:0]            red_ff, red_in;
   logic [7:0]            green_ff, green_in;
   logic                  rsp_valid_ff;

   logic          req_fire;
   logic          s1_fire;
   logic          pal_we;
   logic          idx_ok;
   logic [AW-1:0] raddr_a;
   logic [AW-1:0] raddr_b;
   logic [15:0]   req_s16;
   logic [15:0]   s16;

   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   assign req_s16 = 16'(req_param[SW-1:0]);
   assign idx_ok  = {1'b0, req_param[7:0]} < 9'(PALETTE_DEPTH);
   assign raddr_a = req_param[AW-1:0];
   assign raddr_b = AW'(sgrpad_pkg::pal_code_index(req_s16));
   assign pal_we  = req_fire && req_func && ({1'b0, req_pal_index} < 9'(PALETTE_DEPTH));

   // Both possible palette reads are issued at acceptance: the index form
   // of a 38/48/58 argument and the 16-color code form. The pen stage picks.
   always_ff @(posedge clock) begin
      if (pal_we) begin
         palette_ff[req_pal_index[AW-1:0]] <= req_pal_rgb;
      end
      if (req_fire) begin
         rd_a_ff <= palette_ff[raddr_a];
         rd_b_ff <= palette_ff[raddr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_func_ff   <= req_func;
         s1_param_ff  <= req_param[SW-1:0];
         s1_last_ff   <= req_last;
         s1_idx_ok_ff <= idx_ok;
      end
   end

   assign s16 = 16'(s1_param_ff);

   always_comb begin
      sgrpad_pkg::pen_type p;
      logic do_code;
      p         = pen_ff;
      phase_in  = sgrpad_pkg::PH_IDLE;
      target_in = target_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      do_code   = 1'b0;

      if (s1_func_ff) begin
         // A palette write leaves the parse position where it was.
         phase_in = phase_ff;
      end else begin
         unique case (phase_ff)
            sgrpad_pkg::PH_UL_STYLE: begin
               if (s16 <= sgrpad_pkg::UL_STYLE_MAX) begin
                  p.underline = s16[2:0];
               end else begin
                  do_code = 1'b1;
               end
            end
            sgrpad_pkg::PH_COLOR_MODE: begin
               if (s16 == sgrpad_pkg::MODE_PALETTE) begin
                  phase_in = sgrpad_pkg::PH_PAL_INDEX;
               end else if (s16 == sgrpad_pkg::MODE_RGB) begin
                  red_in   = 8'd0;
                  green_in = 8'd0;
                  phase_in = sgrpad_pkg::PH_RED;
               end else begin
                  p = sgrpad_pkg::color_set(p, target_ff, 24'd0);
               end
            end
            sgrpad_pkg::PH_PAL_INDEX: begin
               p = sgrpad_pkg::color_set(p, target_ff, s1_idx_ok_ff ? rd_a_ff : 24'd0);
            end
            sgrpad_pkg::PH_RED: begin
               red_in   = s16[7:0];
               phase_in = sgrpad_pkg::PH_GREEN;
            end
            sgrpad_pkg::PH_GREEN: begin
               green_in = s16[7:0];
               phase_in = sgrpad_pkg::PH_BLUE;
            end
            sgrpad_pkg::PH_BLUE: begin
               p = sgrpad_pkg::color_set(p, target_ff, {red_ff, green_ff, s16[7:0]});
            end
            default: do_code = 1'b1;
         endcase

         if (do_code) begin
            unique case (s16)
               sgrpad_pkg::CODE_RESET:      p = sgrpad_pkg::PEN_CLEAR;
               sgrpad_pkg::CODE_BOLD:       p.attrs[0] = 1'b1;
               sgrpad_pkg::CODE_ITALIC:     p.attrs[1] = 1'b1;
               sgrpad_pkg::CODE_BLINK:      p.attrs[2] = 1'b1;
               sgrpad_pkg::CODE_REVERSE:    p.attrs[3] = 1'b1;
               sgrpad_pkg::CODE_STRIKE:     p.attrs[4] = 1'b1;
               sgrpad_pkg::CODE_NO_BOLD:    p.attrs[0] = 1'b0;
               sgrpad_pkg::CODE_NO_ITALIC:  p.attrs[1] = 1'b0;
               sgrpad_pkg::CODE_NO_BLINK:   p.attrs[2] = 1'b0;
               sgrpad_pkg::CODE_NO_REVERSE: p.attrs[3] = 1'b0;
               sgrpad_pkg::CODE_NO_STRIKE:  p.attrs[4] = 1'b0;
               sgrpad_pkg::CODE_NO_UL:      p.underline = 3'd0;
               sgrpad_pkg::CODE_UNDERLINE: begin
                  p.underline = 3'd1;
                  phase_in    = sgrpad_pkg::PH_UL_STYLE;
               end
               sgrpad_pkg::CODE_FG_EXT: begin
                  target_in = sgrpad_pkg::TGT_FG;
                  phase_in  = sgrpad_pkg::PH_COLOR_MODE;
               end
               sgrpad_pkg::CODE_BG_EXT: begin
                  target_in = sgrpad_pkg::TGT_BG;
                  phase_in  = sgrpad_pkg::PH_COLOR_MODE;
               end
               sgrpad_pkg::CODE_UL_EXT: begin
                  target_in = sgrpad_pkg::TGT_UL;
                  phase_in  = sgrpad_pkg::PH_COLOR_MODE;
               end
               sgrpad_pkg::CODE_FG_DEF: p = sgrpad_pkg::color_default(p, sgrpad_pkg::TGT_FG);
               sgrpad_pkg::CODE_BG_DEF: p = sgrpad_pkg::color_default(p, sgrpad_pkg::TGT_BG);
               sgrpad_pkg::CODE_UL_DEF: p = sgrpad_pkg::color_default(p, sgrpad_pkg::TGT_UL);
               default: begin
                  if (sgrpad_pkg::in_span(s16, sgrpad_pkg::CODE_FG_BASE) ||
                      sgrpad_pkg::in_span(s16, sgrpad_pkg::CODE_FG_BRIGHT)) begin
                     p = sgrpad_pkg::color_set(p, sgrpad_pkg::TGT_FG, rd_b_ff);
                  end else if (sgrpad_pkg::in_span(s16, sgrpad_pkg::CODE_BG_BASE) ||
                               sgrpad_pkg::in_span(s16, sgrpad_pkg::CODE_BG_BRIGHT)) begin
                     p = sgrpad_pkg::color_set(p, sgrpad_pkg::TGT_BG, rd_b_ff);
                  end
               end
            endcase
         end

         // An early end zero-fills a pending color; with no mode, it reverts to default.
         if (s1_last_ff) begin
            unique case (phase_in)
               sgrpad_pkg::PH_COLOR_MODE: p = sgrpad_pkg::color_default(p, target_in);
               sgrpad_pkg::PH_PAL_INDEX:  p = sgrpad_pkg::color_set(p, target_in, 24'd0);
               sgrpad_pkg::PH_RED:        p = sgrpad_pkg::color_set(p, target_in, 24'd0);
               sgrpad_pkg::PH_GREEN:
                  p = sgrpad_pkg::color_set(p, target_in, {red_in, 16'd0});
               sgrpad_pkg::PH_BLUE:
                  p = sgrpad_pkg::color_set(p, target_in, {red_in, green_in, 8'd0});
               default: p = p;
            endcase
            phase_in = sgrpad_pkg::PH_IDLE;
         end
      end
      pen_in = p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff       <= sgrpad_pkg::PEN_CLEAR;
         phase_ff     <= sgrpad_pkg::PH_IDLE;
         target_ff    <= sgrpad_pkg::TGT_FG;
         red_ff       <= 8'd0;
         green_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_fire) begin
            pen_ff    <= pen_in;
            phase_ff  <= phase_in;
            target_ff <= target_in;
            red_ff    <= red_in;
            green_ff  <= green_in;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_attr_bits       = pen_ff.attrs;
   assign rsp_underline_style = pen_ff.underline;
   assign rsp_fg_color        = pen_ff.fg;
   assign rsp_bg_color        = pen_ff.bg;
   assign rsp_ul_color        = pen_ff.ulc;
   assign rsp_default_flags   = pen_ff.defaults;

   // A palette write beat must leave the pen untouched.
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_func_ff) |=> (pen_ff == $past(pen_ff)))
      else $error("pen changed on a palette write beat");

   // The last parameter of a sequence always returns the parser to idle.
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !s1_func_ff && s1_last_ff) |=> (phase_ff == sgrpad_pkg::PH_IDLE))
      else $error("parser not idle after the last parameter");

   // The pen only moves when a beat leaves the input stage.
   assert property (@(posedge clock) disable iff (reset)
      (!reset && !s1_fire) |=> $stable(pen_ff))
      else $error("pen changed without a beat");

   // A new result beat appears only after a beat left the input stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_fire))
      else $error("result beat without a source beat");

endmodule

>>> bench/sgr_pen_attribute_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// SGR pen attribute decoder testbench
// Drives SGR parameter beats and palette writes through the request channel,
// predicts the pen after every beat and compares each response beat field by
// field. Both channels idle at random, and the response side stalls for long
// stretches so that the decoder fills up and throttles its input.
// ----------------------------------------------------------------------------
module sgr_pen_attribute_decoder_top_tb;

   localparam int unsigned PARAM_WIDTH = 16;
   localparam int unsigned HOLD_CYCLES = 120;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int ATTR_BOLD = 0;
   localparam int ATTR_ITALIC = 1;
   localparam int ATTR_BLINK = 2;
   localparam int ATTR_REVERSE = 3;
   localparam int ATTR_STRIKE = 4;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_func;
   logic [PARAM_WIDTH-1:0] req_param;
   logic                   req_last;
   logic [7:0]             req_pal_index;
   logic [23:0]            req_pal_rgb;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [4:0]             rsp_attr_bits;
   logic [2:0]             rsp_underline_style;
   logic [23:0]            rsp_fg_color;
   logic [23:0]            rsp_bg_color;
   logic [23:0]            rsp_ul_color;
   logic [2:0]             rsp_default_flags;

   // Predicted decoder state.
   sgrpad_pkg::pen_type   pen_q;
   sgrpad_pkg::phase_type phase_q;
   logic [1:0]            target_q;
   logic [7:0]            red_q;
   logic [7:0]            green_q;
   logic [23:0]           pal_mem [256];
   bit                    pal_loaded [256];

   sgrpad_pkg::pen_type expected_pens [$];
   sgrpad_pkg::pen_type want;
   logic [15:0]         seq_buf [$];
   int                  beats_sent;
   int                  beats_checked;
   int                  errors;
   bit                  quiet;
   int                  hold_req;
   int                  hold_taken;
   int                  hold_left;

   sgr_pen_attribute_decoder_top #(
      .PALETTE_DEPTH(256),
      .PARAM_WIDTH  (PARAM_WIDTH)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_param          (req_param),
      .req_last           (req_last),
      .req_pal_index      (req_pal_index),
      .req_pal_rgb        (req_pal_rgb),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_attr_bits      (rsp_attr_bits),
      .rsp_underline_style(rsp_underline_style),
      .rsp_fg_color       (rsp_fg_color),
      .rsp_bg_color       (rsp_bg_color),
      .rsp_ul_color       (rsp_ul_color),
      .rsp_default_flags  (rsp_default_flags)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #5 clock = ~clock;
      end
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Pen prediction
   // ------------------------------------------------------------------------
   function automatic void paint(input logic [1:0] tgt, input logic [23:0] rgb);
      case (tgt)
         sgrpad_pkg::TGT_FG: begin
            pen_q.fg = rgb;
            pen_q.defaults[0] = 1'b0;
         end
         sgrpad_pkg::TGT_BG: begin
            pen_q.bg = rgb;
            pen_q.defaults[1] = 1'b0;
         end
         sgrpad_pkg::TGT_UL: begin
            pen_q.ulc = rgb;
            pen_q.defaults[2] = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // Tells whether s is one of the 16-color codes, and which entry it uses.
   function automatic bit color_code(input logic [15:0] s, output logic [1:0] tgt,
                                     output logic [7:0] idx);
      logic [15:0] offset;
      tgt = sgrpad_pkg::TGT_FG;
      idx = 8'd0;
      if (s >= sgrpad_pkg::CODE_FG_BASE &&
          s <= sgrpad_pkg::CODE_FG_BASE + sgrpad_pkg::COLOR_SPAN) begin
         offset = s - sgrpad_pkg::CODE_FG_BASE;
      end else if (s >= sgrpad_pkg::CODE_FG_BRIGHT &&
                   s <= sgrpad_pkg::CODE_FG_BRIGHT + sgrpad_pkg::COLOR_SPAN) begin
         offset = s - sgrpad_pkg::CODE_FG_BRIGHT + 16'd8;
      end else if (s >= sgrpad_pkg::CODE_BG_BASE &&
                   s <= sgrpad_pkg::CODE_BG_BASE + sgrpad_pkg::COLOR_SPAN) begin
         offset = s - sgrpad_pkg::CODE_BG_BASE;
         tgt = sgrpad_pkg::TGT_BG;
      end else if (s >= sgrpad_pkg::CODE_BG_BRIGHT &&
                   s <= sgrpad_pkg::CODE_BG_BRIGHT + sgrpad_pkg::COLOR_SPAN) begin
         offset = s - sgrpad_pkg::CODE_BG_BRIGHT + 16'd8;
         tgt = sgrpad_pkg::TGT_BG;
      end else begin
         return 1'b0;
      end
      idx = offset[7:0];
      return 1'b1;
   endfunction

   function automatic void run_code(input logic [15:0] s);
      logic [1:0] tgt;
      logic [7:0] idx;
      case (s)
         sgrpad_pkg::CODE_RESET:      pen_q = sgrpad_pkg::PEN_CLEAR;
         sgrpad_pkg::CODE_BOLD:       pen_q.attrs[ATTR_BOLD] = 1'b1;
         sgrpad_pkg::CODE_ITALIC:     pen_q.attrs[ATTR_ITALIC] = 1'b1;
         sgrpad_pkg::CODE_BLINK:      pen_q.attrs[ATTR_BLINK] = 1'b1;
         sgrpad_pkg::CODE_REVERSE:    pen_q.attrs[ATTR_REVERSE] = 1'b1;
         sgrpad_pkg::CODE_STRIKE:     pen_q.attrs[ATTR_STRIKE] = 1'b1;
         sgrpad_pkg::CODE_NO_BOLD:    pen_q.attrs[ATTR_BOLD] = 1'b0;
         sgrpad_pkg::CODE_NO_ITALIC:  pen_q.attrs[ATTR_ITALIC] = 1'b0;
         sgrpad_pkg::CODE_NO_BLINK:   pen_q.attrs[ATTR_BLINK] = 1'b0;
         sgrpad_pkg::CODE_NO_REVERSE: pen_q.attrs[ATTR_REVERSE] = 1'b0;
         sgrpad_pkg::CODE_NO_STRIKE:  pen_q.attrs[ATTR_STRIKE] = 1'b0;
         sgrpad_pkg::CODE_NO_UL:      pen_q.underline = 3'd0;
         sgrpad_pkg::CODE_UNDERLINE: begin
            pen_q.underline = 3'd1;
            phase_q = sgrpad_pkg::PH_UL_STYLE;
         end
         sgrpad_pkg::CODE_FG_EXT: begin
            target_q = sgrpad_pkg::TGT_FG;
            phase_q = sgrpad_pkg::PH_COLOR_MODE;
         end
         sgrpad_pkg::CODE_BG_EXT: begin
            target_q = sgrpad_pkg::TGT_BG;
            phase_q = sgrpad_pkg::PH_COLOR_MODE;
         end
         sgrpad_pkg::CODE_UL_EXT: begin
            target_q = sgrpad_pkg::TGT_UL;
            phase_q = sgrpad_pkg::PH_COLOR_MODE;
         end
         sgrpad_pkg::CODE_FG_DEF:     pen_q.defaults[0] = 1'b1;
         sgrpad_pkg::CODE_BG_DEF:     pen_q.defaults[1] = 1'b1;
         sgrpad_pkg::CODE_UL_DEF:     pen_q.defaults[2] = 1'b1;
         default: begin
            if (color_code(s, tgt, idx)) begin
               paint(tgt, pal_mem[idx]);
            end
         end
      endcase
   endfunction

   function automatic void take_param(input logic [15:0] s);
      sgrpad_pkg::phase_type ph;
      ph = phase_q;
      phase_q = sgrpad_pkg::PH_IDLE;
      case (ph)
         sgrpad_pkg::PH_UL_STYLE: begin
            if (s <= sgrpad_pkg::UL_STYLE_MAX) begin
               pen_q.underline = s[2:0];
            end else begin
               run_code(s);
            end
         end
         sgrpad_pkg::PH_COLOR_MODE: begin
            if (s == sgrpad_pkg::MODE_PALETTE) begin
               phase_q = sgrpad_pkg::PH_PAL_INDEX;
            end else if (s == sgrpad_pkg::MODE_RGB) begin
               red_q = 8'd0;
               green_q = 8'd0;
               phase_q = sgrpad_pkg::PH_RED;
            end else begin
               paint(target_q, 24'd0);
            end
         end
         sgrpad_pkg::PH_PAL_INDEX: paint(target_q, pal_mem[s[7:0]]);
         sgrpad_pkg::PH_RED: begin
            red_q = s[7:0];
            phase_q = sgrpad_pkg::PH_GREEN;
         end
         sgrpad_pkg::PH_GREEN: begin
            green_q = s[7:0];
            phase_q = sgrpad_pkg::PH_BLUE;
         end
         sgrpad_pkg::PH_BLUE: paint(target_q, {red_q, green_q, s[7:0]});
         default: run_code(s);
      endcase
   endfunction

   // An early end completes the pending color with zeros for missing parts, or defaults it before a mode.
   function automatic void close_sequence();
      case (phase_q)
         sgrpad_pkg::PH_COLOR_MODE: pen_q.defaults[target_q] = 1'b1;
         sgrpad_pkg::PH_PAL_INDEX:  paint(target_q, 24'd0);
         sgrpad_pkg::PH_RED:        paint(target_q, 24'd0);
         sgrpad_pkg::PH_GREEN:      paint(target_q, {red_q, 16'd0});
         sgrpad_pkg::PH_BLUE:       paint(target_q, {red_q, green_q, 8'd0});
         default: ;
      endcase
      phase_q = sgrpad_pkg::PH_IDLE;
   endfunction

   function automatic sgrpad_pkg::pen_type predict_pen(input logic func,
                                                       input logic [15:0] param,
                                                       input logic last,
                                                       input logic [7:0] idx,
                                                       input logic [23:0] rgb);
      if (func) begin
         pal_mem[idx] = rgb;
         pal_loaded[idx] = 1'b1;
      end else begin
         take_param(param);
         if (last) begin
            close_sequence();
         end
      end
      return pen_q;
   endfunction

   // Palette entry that a parameter would read in the current parse phase.
   function automatic bit reads_palette(input logic [15:0] s, output logic [7:0] idx);
      logic [1:0] tgt;
      idx = s[7:0];
      if (phase_q == sgrpad_pkg::PH_PAL_INDEX) begin
         return 1'b1;
      end
      if (phase_q != sgrpad_pkg::PH_IDLE && phase_q != sgrpad_pkg::PH_UL_STYLE) begin
         return 1'b0;
      end
      if (phase_q == sgrpad_pkg::PH_UL_STYLE && s <= sgrpad_pkg::UL_STYLE_MAX) begin
         return 1'b0;
      end
      return color_code(s, tgt, idx);
   endfunction

   function automatic logic [15:0] color_byte();
      if ($urandom_range(7) == 0) begin
         return 16'($urandom_range(65535));
      end
      return 16'($urandom_range(255));
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // Entered and left at a falling edge; valid stays high on exit so that a
   // following beat goes out back to back.
   task automatic send_beat(input logic func, input logic [15:0] param, input logic last,
                            input logic [7:0] idx, input logic [23:0] rgb);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(99) < 14) begin
         gap = $urandom_range(3, 1);
      end
      repeat (gap) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_func = func;
      req_param = param;
      req_last = last;
      req_pal_index = idx;
      req_pal_rgb = rgb;
      req_valid = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      expected_pens.push_back(predict_pen(func, param, last, idx, rgb));
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_pal_write(input logic [7:0] idx, input logic [23:0] rgb);
      send_beat(1'b1, 16'($urandom_range(65535)), 1'($urandom_range(1)), idx, rgb);
   endtask

   // A parameter that would read a palette entry never written gets the
   // entry loaded first.
   task automatic send_param(input logic [15:0] value, input logic last);
      logic [7:0] idx;
      if (reads_palette(value, idx) && !pal_loaded[idx]) begin
         send_pal_write(idx, 24'($urandom()));
      end
      send_beat(1'b0, value, last, 8'($urandom()), 24'($urandom()));
   endtask

   task automatic play_sequence(input int write_pct);
      for (int i = 0; i < seq_buf.size(); i++) begin
         if ($urandom_range(99) < write_pct) begin
            send_pal_write(8'($urandom()), 24'($urandom()));
         end
         send_param(seq_buf[i], i == seq_buf.size() - 1);
      end
   endtask

   task automatic random_sequence();
      int          elems;
      int          pick;
      int          n_tail;
      bit          cut;
      logic [15:0] tail [4];
      seq_buf.delete();
      elems = $urandom_range(5, 1);
      cut = 1'b0;
      for (int k = 0; k < elems && !cut; k++) begin
         pick = $urandom_range(99);
         if (pick < 22) begin
            case ($urandom_range(10))
               0:       seq_buf.push_back(sgrpad_pkg::CODE_BOLD);
               1:       seq_buf.push_back(sgrpad_pkg::CODE_ITALIC);
               2:       seq_buf.push_back(sgrpad_pkg::CODE_BLINK);
               3:       seq_buf.push_back(sgrpad_pkg::CODE_REVERSE);
               4:       seq_buf.push_back(sgrpad_pkg::CODE_STRIKE);
               5:       seq_buf.push_back(sgrpad_pkg::CODE_NO_BOLD);
               6:       seq_buf.push_back(sgrpad_pkg::CODE_NO_ITALIC);
               7:       seq_buf.push_back(sgrpad_pkg::CODE_NO_BLINK);
               8:       seq_buf.push_back(sgrpad_pkg::CODE_NO_REVERSE);
               9:       seq_buf.push_back(sgrpad_pkg::CODE_NO_STRIKE);
               default: seq_buf.push_back(sgrpad_pkg::CODE_NO_UL);
            endcase
         end else if (pick < 32) begin
            seq_buf.push_back(sgrpad_pkg::CODE_UNDERLINE);
            if ($urandom_range(1)) begin
               seq_buf.push_back(16'($urandom_range(7)));
            end
         end else if (pick < 47) begin
            case ($urandom_range(3))
               0: seq_buf.push_back(16'(sgrpad_pkg::CODE_FG_BASE + $urandom_range(7)));
               1: seq_buf.push_back(16'(sgrpad_pkg::CODE_FG_BRIGHT + $urandom_range(7)));
               2: seq_buf.push_back(16'(sgrpad_pkg::CODE_BG_BASE + $urandom_range(7)));
               default:
                  seq_buf.push_back(16'(sgrpad_pkg::CODE_BG_BRIGHT + $urandom_range(7)));
            endcase
         end else if (pick < 77) begin
            case ($urandom_range(2))
               0:       seq_buf.push_back(sgrpad_pkg::CODE_FG_EXT);
               1:       seq_buf.push_back(sgrpad_pkg::CODE_BG_EXT);
               default: seq_buf.push_back(sgrpad_pkg::CODE_UL_EXT);
            endcase
            pick = $urandom_range(99);
            if (pick < 45) begin
               tail[0] = sgrpad_pkg::MODE_PALETTE;
               tail[1] = color_byte();
               n_tail = 2;
            end else if (pick < 85) begin
               tail[0] = sgrpad_pkg::MODE_RGB;
               tail[1] = color_byte();
               tail[2] = color_byte();
               tail[3] = color_byte();
               n_tail = 4;
            end else begin
               tail[0] = 16'($urandom_range(65535));
               n_tail = 1;
            end
            // Now and then the sequence ends inside the color argument.
            if ($urandom_range(99) < 15) begin
               n_tail = $urandom_range(n_tail - 1, 0);
               cut = 1'b1;
            end
            for (int j = 0; j < n_tail; j++) begin
               seq_buf.push_back(tail[j]);
            end
         end else if (pick < 85) begin
            case ($urandom_range(2))
               0:       seq_buf.push_back(sgrpad_pkg::CODE_FG_DEF);
               1:       seq_buf.push_back(sgrpad_pkg::CODE_BG_DEF);
               default: seq_buf.push_back(sgrpad_pkg::CODE_UL_DEF);
            endcase
         end else if (pick < 91) begin
            seq_buf.push_back(sgrpad_pkg::CODE_RESET);
         end else begin
            seq_buf.push_back(16'($urandom_range(65535)));
         end
      end
      play_sequence(3);
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
      hold_taken = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_taken) begin
            hold_taken = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = quiet || ($urandom_range(99) >= 20);
         end
      end
   end

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= REPORT_LIMIT) begin
         $display("ERROR: beat %0d: %s", beats_checked, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [23:0] exp_v,
                              input logic [23:0] got_v);
      if (got_v !== exp_v) begin
         flag_error($sformatf("%s expected %h got %h", name, exp_v, got_v));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pens.size() == 0) begin
            flag_error("response beat with nothing outstanding");
         end else begin
            want = expected_pens.pop_front();
            check_field("attr_bits", 24'(want.attrs), 24'(rsp_attr_bits));
            check_field("underline_style", 24'(want.underline), 24'(rsp_underline_style));
            check_field("fg_color", want.fg, rsp_fg_color);
            check_field("bg_color", want.bg, rsp_bg_color);
            check_field("ul_color", want.ulc, rsp_ul_color);
            check_field("default_flags", 24'(want.defaults), 24'(rsp_default_flags));
         end
         beats_checked++;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_attributes();
      seq_buf = {sgrpad_pkg::CODE_RESET};
      play_sequence(0);
      seq_buf = {16'hFFFF, sgrpad_pkg::CODE_BOLD, sgrpad_pkg::CODE_ITALIC,
                 sgrpad_pkg::CODE_BLINK, sgrpad_pkg::CODE_REVERSE, sgrpad_pkg::CODE_STRIKE,
                 sgrpad_pkg::CODE_UNDERLINE, sgrpad_pkg::UL_STYLE_MAX};
      play_sequence(0);
      seq_buf = {sgrpad_pkg::CODE_NO_BOLD, sgrpad_pkg::CODE_NO_ITALIC,
                 sgrpad_pkg::CODE_NO_BLINK, sgrpad_pkg::CODE_NO_REVERSE,
                 sgrpad_pkg::CODE_NO_STRIKE, sgrpad_pkg::CODE_UNDERLINE,
                 sgrpad_pkg::CODE_NO_UL};
      play_sequence(0);
   endtask

   task automatic test_indexed_colors();
      send_pal_write(8'd0, 24'hFFFFFF);
      send_pal_write(8'd255, 24'h5A0FF0);
      seq_buf = {sgrpad_pkg::CODE_FG_BASE,
                 16'(sgrpad_pkg::CODE_FG_BRIGHT + sgrpad_pkg::COLOR_SPAN),
                 sgrpad_pkg::CODE_BG_BASE,
                 16'(sgrpad_pkg::CODE_BG_BRIGHT + sgrpad_pkg::COLOR_SPAN),
                 sgrpad_pkg::CODE_UL_EXT, sgrpad_pkg::MODE_PALETTE, 16'd255};
      play_sequence(0);
   endtask

   task automatic test_direct_colors();
      seq_buf = {sgrpad_pkg::CODE_FG_EXT, sgrpad_pkg::MODE_RGB, 16'hFFFF, 16'd0, 16'd128};
      play_sequence(0);
      // A palette write in the middle of a color argument keeps the parse.
      send_param(sgrpad_pkg::CODE_BG_EXT, 1'b0);
      send_param(sgrpad_pkg::MODE_RGB, 1'b0);
      send_pal_write(8'd128, 24'h000000);
      seq_buf = {16'd1, 16'd2, 16'd3, sgrpad_pkg::CODE_UL_EXT, 16'd7,
                 sgrpad_pkg::CODE_FG_DEF, sgrpad_pkg::CODE_BG_DEF, sgrpad_pkg::CODE_UL_DEF};
      play_sequence(0);
   endtask

   task automatic test_early_ends();
      seq_buf = {sgrpad_pkg::CODE_UL_EXT};
      play_sequence(0);
      seq_buf = {sgrpad_pkg::CODE_FG_EXT, sgrpad_pkg::MODE_PALETTE};
      play_sequence(0);
      seq_buf = {sgrpad_pkg::CODE_BG_EXT, sgrpad_pkg::MODE_RGB};
      play_sequence(0);
      seq_buf = {sgrpad_pkg::CODE_UL_EXT, sgrpad_pkg::MODE_RGB, 16'd200};
      play_sequence(0);
      seq_buf = {sgrpad_pkg::CODE_FG_EXT, sgrpad_pkg::MODE_RGB, 16'd17, 16'd34};
      play_sequence(0);
   endtask

   task automatic test_random_sequences(input int count);
      int start;
      start = beats_sent;
      while (beats_sent - start < count) begin
         if ($urandom_range(99) < 8) begin
            send_pal_write(8'($urandom()), 24'($urandom()));
         end else begin
            random_sequence();
         end
      end
   endtask

   task automatic test_steady_stream(input int count);
      quiet = 1'b1;
      test_random_sequences(count);
      quiet = 1'b0;
   endtask

   // The response side holds off while requests keep coming, so the decoder
   // backs up and drops req_ready.
   task automatic test_output_stall();
      hold_req++;
      test_steady_stream(60);
   endtask

   task automatic test_drain_pause();
      req_valid = 1'b0;
      while (expected_pens.size() != 0) begin
         @(negedge clock);
      end
      test_random_sequences(40);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = 1'b0;
      req_param = '0;
      req_last = 1'b0;
      req_pal_index = 8'd0;
      req_pal_rgb = 24'd0;
      quiet = 1'b0;
      hold_req = 0;
      beats_sent = 0;
      beats_checked = 0;
      errors = 0;
      pen_q = sgrpad_pkg::PEN_CLEAR;
      phase_q = sgrpad_pkg::PH_IDLE;
      target_q = sgrpad_pkg::TGT_FG;
      red_q = 8'd0;
      green_q = 8'd0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_attributes();
      test_indexed_colors();
      test_direct_colors();
      test_early_ends();
      test_random_sequences(450);
      test_steady_stream(200);
      test_output_stall();
      test_random_sequences(450);
      test_drain_pause();

      req_valid = 1'b0;
      while (expected_pens.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (errors == 0 && expected_pens.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
